[src/sadsr_pkg.sv]
// shared types, widths and constants for the stereo adsr envelope gain block
`default_nettype none

package sadsr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 15;
    localparam int LENGTH_BITS    = 18;

    localparam int GAIN_W = GAIN_FRAC_BITS + 1;
    localparam int POS_W  = LENGTH_BITS + 2;

    // divider: dividend up to gain times length, quotient never above one
    localparam int DIV_NUM_W = GAIN_W + LENGTH_BITS;
    localparam int DIV_Q_W   = GAIN_W;

    // shared multiplier: signed a covers lengths, gains and samples
    localparam int MUL_A_W0 = (LENGTH_BITS > GAIN_W) ? LENGTH_BITS + 1 : GAIN_W + 1;
    localparam int MUL_A_W  = (MUL_A_W0 > SAMPLE_BITS) ? MUL_A_W0 : SAMPLE_BITS;
    localparam int MUL_P_W  = MUL_A_W + GAIN_W + 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = (LENGTH_BITS > GAIN_W) ? LENGTH_BITS : GAIN_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_LENGTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_LENGTH   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_SUSTAIN_LENGTH = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_LENGTH = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] CFG_SUSTAIN_LEVEL  = CFG_INDEX_W'(4);

    localparam logic [GAIN_W-1:0] GAIN_ONE  = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [GAIN_W-1:0] GAIN_HALF = {2'b01, {(GAIN_FRAC_BITS-1){1'b0}}};

    localparam int ONE_INT = 2 ** GAIN_FRAC_BITS;
    localparam logic [GAIN_W-1:0] SKEW_ATTACK  = GAIN_W'((98 * ONE_INT + 50) / 100);
    localparam logic [GAIN_W-1:0] SKEW_DECAY   = GAIN_W'((99 * ONE_INT + 50) / 100);
    localparam logic [GAIN_W-1:0] SKEW_RELEASE = GAIN_W'((97 * ONE_INT + 50) / 100);

    localparam logic [LENGTH_BITS-1:0] ATTACK_LENGTH_RST  = LENGTH_BITS'(144);
    localparam logic [LENGTH_BITS-1:0] DECAY_LENGTH_RST   = LENGTH_BITS'(43200);
    localparam logic [LENGTH_BITS-1:0] SUSTAIN_LENGTH_RST = LENGTH_BITS'(48000);
    localparam logic [LENGTH_BITS-1:0] RELEASE_LENGTH_RST = LENGTH_BITS'(96000);
    localparam logic [GAIN_W-1:0]      SUSTAIN_LEVEL_RST  = GAIN_W'(11469);

    typedef struct packed {
        logic                          action;
        logic [GAIN_W-1:0]             velocity;
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } sadsr_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          note_done;
        logic                          voice_active;
    } sadsr_out_t;

endpackage

`default_nettype wire

[src/sadsr_div.sv]
// restoring divider, one quotient bit per cycle, quotient known to fit DIV_Q_W bits
`default_nettype none

module sadsr_div
    import sadsr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [DIV_NUM_W-1:0]   dividend,
    input  wire logic [LENGTH_BITS-1:0] divisor,
    output logic                        done,
    output logic [DIV_Q_W-1:0]          quotient
);

    localparam int CNT_W = $clog2(DIV_Q_W);

    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [DIV_Q_W-1:0]     lo_reg, lo_next;
    logic [LENGTH_BITS-1:0] den_reg, den_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [LENGTH_BITS:0]   trial;
    logic                   fits;

    assign trial = {rem_reg, lo_reg[DIV_Q_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        den_next   = den_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            // upper part is already below the divisor
            rem_next   = dividend[DIV_NUM_W-1:DIV_Q_W];
            lo_next    = dividend[DIV_Q_W-1:0];
            den_next   = divisor;
            count_next = CNT_W'(DIV_Q_W - 1);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? LENGTH_BITS'(trial - {1'b0, den_reg}) : trial[LENGTH_BITS-1:0];
            lo_next  = {lo_reg[DIV_Q_W-2:0], fits};
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            lo_reg    <= '0;
            den_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            rem_reg   <= rem_next;
            lo_reg    <= lo_next;
            den_reg   <= den_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

`default_nettype wire

[src/stereo_adsr_envelope_gain.sv]
// top level: stereo linear adsr envelope gain, one voice, shared multiplier and divider
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------
//  in       | in        | in_valid / in_ready    | in_data (action, velocity, samples)
//  out      | out       | out_valid / out_ready  | out_data (samples, done, active)
//  cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// start items and idle samples skip the arithmetic; running samples in attack, decay and
// sustain go once through the 16-step serial divider and release runs it up to twice,
// and all products go through the single shared multiplier.
// in_ready is high only in the idle state; a finished item waits in the output
// register, so a stalled out_ready holds back only the item after the next one.
// reset clears the voice and loads the default register values; cfg_ready is always high.
`default_nettype none

module stereo_adsr_envelope_gain
    import sadsr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire sadsr_in_t              in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output sadsr_out_t                  out_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_MUL_SLOPE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_SUS,
        ST_REL_CHECK,
        ST_MUL_REL,
        ST_SKEW,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_SCALE_L,
        ST_SCALE_R,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        SEG_ATTACK,
        SEG_DECAY,
        SEG_SUSTAIN,
        SEG_RELEASE
    } seg_t;

    state_t state_reg, state_next;
    seg_t   seg_reg, seg_next;

    logic [LENGTH_BITS-1:0] att_len_reg, att_len_next;
    logic [LENGTH_BITS-1:0] dec_len_reg, dec_len_next;
    logic [LENGTH_BITS-1:0] sus_len_reg, sus_len_next;
    logic [LENGTH_BITS-1:0] rel_len_reg, rel_len_next;
    logic [GAIN_W-1:0]      level_reg, level_next;

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [POS_W-1:0]       off_reg, off_next;
    logic                   running_reg, running_next;
    logic [GAIN_W-1:0]      gain_reg, gain_next;
    logic                   rel_pass_reg, rel_pass_next;

    logic signed [SAMPLE_BITS-1:0] sl_reg, sl_next;
    logic signed [SAMPLE_BITS-1:0] sr_reg, sr_next;
    logic [GAIN_W-1:0]      env_reg, env_next;
    logic [GAIN_W-1:0]      envr_reg, envr_next;

    logic [DIV_NUM_W-1:0]   div_num_reg, div_num_next;
    logic [LENGTH_BITS-1:0] div_den_reg, div_den_next;

    sadsr_out_t             res_reg, res_next;
    sadsr_out_t             out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic [GAIN_W-1:0]         mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [MUL_P_W-1:0] mul_r;
    logic signed [MUL_P_W-1:0] mul_q;

    logic                   div_start;
    logic                   div_done;
    logic [DIV_Q_W-1:0]     div_q;

    logic [GAIN_W-1:0]      level_c;
    logic [LENGTH_BITS-1:0] cur_len;
    logic [LENGTH_BITS-1:0] off_len;

    function automatic logic [LENGTH_BITS-1:0] seg_len(
        input seg_t s,
        input logic [LENGTH_BITS-1:0] a,
        input logic [LENGTH_BITS-1:0] d,
        input logic [LENGTH_BITS-1:0] su,
        input logic [LENGTH_BITS-1:0] r
    );
        logic [LENGTH_BITS-1:0] v;
        case (s)
            SEG_ATTACK:  v = a;
            SEG_DECAY:   v = d;
            SEG_SUSTAIN: v = su;
            SEG_RELEASE: v = r;
            default:     v = r;
        endcase
        return v;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [MUL_P_W-1:0] v);
        logic [MUL_P_W-SAMPLE_BITS:0] hi;
        logic [SAMPLE_BITS-1:0]       r;
        hi = v[MUL_P_W-1:SAMPLE_BITS-1];
        if ((&hi) || !(|hi))
            r = v[SAMPLE_BITS-1:0];
        else if (v[MUL_P_W-1])
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        return r;
    endfunction

    sadsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num_reg),
        .divisor  (div_den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign level_c   = (level_reg > GAIN_ONE) ? GAIN_ONE : level_reg;
    assign cur_len   = seg_len(seg_reg, att_len_reg, dec_len_reg, sus_len_reg, rel_len_reg);
    assign off_len   = off_reg[LENGTH_BITS-1:0];
    assign div_start = (state_reg == ST_DIV_START);

    // shared multiplier, operands picked by the sequencer step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_SLOPE:
            begin
                mul_a = (seg_reg == SEG_RELEASE) ?
                        MUL_A_W'(sus_len_reg - LENGTH_BITS'(1)) : MUL_A_W'(off_len);
                mul_b = GAIN_ONE - level_c;
            end
            ST_MUL_SUS:
            begin
                mul_a = MUL_A_W'(level_c);
                mul_b = envr_reg;
            end
            ST_MUL_REL:
            begin
                mul_a = MUL_A_W'(rel_len_reg - off_len);
                mul_b = env_reg;
            end
            ST_SKEW:
            begin
                mul_a = MUL_A_W'(env_reg);
                case (seg_reg)
                    SEG_ATTACK: mul_b = SKEW_ATTACK;
                    SEG_DECAY:  mul_b = SKEW_DECAY;
                    default:    mul_b = SKEW_RELEASE;
                endcase
            end
            ST_GAIN_L:
            begin
                mul_a = MUL_A_W'(env_reg);
                mul_b = gain_reg;
            end
            ST_GAIN_R:
            begin
                mul_a = MUL_A_W'(envr_reg);
                mul_b = gain_reg;
            end
            ST_SCALE_L:
            begin
                mul_a = MUL_A_W'(sl_reg);
                mul_b = env_reg;
            end
            ST_SCALE_R:
            begin
                mul_a = MUL_A_W'(sr_reg);
                mul_b = envr_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});
    // round half up, floor shift covers both gain products and signed samples
    assign mul_r = mul_p + $signed(MUL_P_W'(GAIN_HALF));
    assign mul_q = mul_r >>> GAIN_FRAC_BITS;

    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        att_len_next   = att_len_reg;
        dec_len_next   = dec_len_reg;
        sus_len_next   = sus_len_reg;
        rel_len_next   = rel_len_reg;
        level_next     = level_reg;
        pos_next       = pos_reg;
        off_next       = off_reg;
        running_next   = running_reg;
        gain_next      = gain_reg;
        rel_pass_next  = rel_pass_reg;
        sl_next        = sl_reg;
        sr_next        = sr_reg;
        env_next       = env_reg;
        envr_next      = envr_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ATTACK_LENGTH:  att_len_next = cfg_data[LENGTH_BITS-1:0];
                CFG_DECAY_LENGTH:   dec_len_next = cfg_data[LENGTH_BITS-1:0];
                CFG_SUSTAIN_LENGTH: sus_len_next = cfg_data[LENGTH_BITS-1:0];
                CFG_RELEASE_LENGTH: rel_len_next = cfg_data[LENGTH_BITS-1:0];
                CFG_SUSTAIN_LEVEL:  level_next   = cfg_data[GAIN_W-1:0];
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_next = '0;
                    if (in_data.action)
                    begin
                        pos_next              = '0;
                        gain_next             = (in_data.velocity > GAIN_ONE) ?
                                                GAIN_ONE : in_data.velocity;
                        running_next          = 1'b1;
                        res_next.voice_active = 1'b1;
                        state_next            = ST_RESULT;
                    end
                    else if (!running_reg)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        off_next      = pos_reg;
                        seg_next      = SEG_ATTACK;
                        rel_pass_next = 1'b0;
                        sl_next       = in_data.left_sample;
                        sr_next       = in_data.right_sample;
                        state_next    = ST_FIND;
                    end
                end
            end
            ST_FIND:
            begin
                // walk the segments, one length compare per cycle
                if ({2'b00, cur_len} > off_reg)
                begin
                    pos_next = pos_reg + 1'b1;
                    case (seg_reg)
                        SEG_ATTACK:
                        begin
                            div_num_next = DIV_NUM_W'({off_len, {GAIN_FRAC_BITS{1'b0}}});
                            div_den_next = att_len_reg;
                            state_next   = ST_DIV_START;
                        end
                        SEG_RELEASE:
                        begin
                            if (sus_len_reg == '0)
                            begin
                                env_next   = '0;
                                state_next = ST_SKEW;
                            end
                            else
                            begin
                                state_next = ST_MUL_SLOPE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_MUL_SLOPE;
                        end
                    endcase
                end
                else if (seg_reg == SEG_RELEASE)
                begin
                    // envelope ran out
                    pos_next           = '0;
                    running_next       = 1'b0;
                    res_next           = '0;
                    res_next.note_done = 1'b1;
                    state_next         = ST_RESULT;
                end
                else
                begin
                    off_next = off_reg - {2'b00, cur_len};
                    seg_next = seg_t'(seg_reg + 2'd1);
                end
            end
            ST_MUL_SLOPE:
            begin
                div_num_next = mul_p[DIV_NUM_W-1:0];
                div_den_next = (seg_reg == SEG_DECAY) ? dec_len_reg : sus_len_reg;
                state_next   = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (seg_reg)
                        SEG_ATTACK:
                        begin
                            env_next   = div_q;
                            state_next = ST_SKEW;
                        end
                        SEG_DECAY:
                        begin
                            env_next   = GAIN_ONE - div_q;
                            state_next = ST_SKEW;
                        end
                        SEG_SUSTAIN:
                        begin
                            envr_next  = GAIN_ONE - div_q;
                            state_next = ST_MUL_SUS;
                        end
                        default:
                        begin
                            if (rel_pass_reg)
                            begin
                                env_next   = div_q;
                                state_next = ST_SKEW;
                            end
                            else
                            begin
                                envr_next  = GAIN_ONE - div_q;
                                state_next = ST_MUL_SUS;
                            end
                        end
                    endcase
                end
            end
            ST_MUL_SUS:
            begin
                env_next = mul_q[GAIN_W-1:0];
                if (seg_reg == SEG_SUSTAIN)
                begin
                    envr_next  = mul_q[GAIN_W-1:0];
                    state_next = ST_GAIN_L;
                end
                else
                begin
                    state_next = ST_REL_CHECK;
                end
            end
            ST_REL_CHECK:
            begin
                // a last sustain value of zero silences the release
                state_next = (env_reg == '0) ? ST_SKEW : ST_MUL_REL;
            end
            ST_MUL_REL:
            begin
                div_num_next  = mul_p[DIV_NUM_W-1:0];
                div_den_next  = rel_len_reg;
                rel_pass_next = 1'b1;
                state_next    = ST_DIV_START;
            end
            ST_SKEW:
            begin
                envr_next  = mul_q[GAIN_W-1:0];
                state_next = ST_GAIN_L;
            end
            ST_GAIN_L:
            begin
                env_next   = mul_q[GAIN_W-1:0];
                state_next = ST_GAIN_R;
            end
            ST_GAIN_R:
            begin
                envr_next  = mul_q[GAIN_W-1:0];
                state_next = ST_SCALE_L;
            end
            ST_SCALE_L:
            begin
                res_next.left_out = sat_sample(mul_q);
                state_next        = ST_SCALE_R;
            end
            ST_SCALE_R:
            begin
                res_next.right_out    = sat_sample(mul_q);
                res_next.note_done    = 1'b0;
                res_next.voice_active = 1'b1;
                state_next            = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_reg       <= SEG_ATTACK;
            att_len_reg   <= ATTACK_LENGTH_RST;
            dec_len_reg   <= DECAY_LENGTH_RST;
            sus_len_reg   <= SUSTAIN_LENGTH_RST;
            rel_len_reg   <= RELEASE_LENGTH_RST;
            level_reg     <= SUSTAIN_LEVEL_RST;
            pos_reg       <= '0;
            off_reg       <= '0;
            running_reg   <= 1'b0;
            gain_reg      <= '0;
            rel_pass_reg  <= 1'b0;
            sl_reg        <= '0;
            sr_reg        <= '0;
            env_reg       <= '0;
            envr_reg      <= '0;
            div_num_reg   <= '0;
            div_den_reg   <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            att_len_reg   <= att_len_next;
            dec_len_reg   <= dec_len_next;
            sus_len_reg   <= sus_len_next;
            rel_len_reg   <= rel_len_next;
            level_reg     <= level_next;
            pos_reg       <= pos_next;
            off_reg       <= off_next;
            running_reg   <= running_next;
            gain_reg      <= gain_next;
            rel_pass_reg  <= rel_pass_next;
            sl_reg        <= sl_next;
            sr_reg        <= sr_next;
            env_reg       <= env_next;
            envr_reg      <= envr_next;
            div_num_reg   <= div_num_next;
            div_den_reg   <= div_den_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire
